FILE: rtl/ial_pkg.sv
// Shared types and codes for the indexed array list block.
// Holds the sequencer state type, command and status codes, and datapath widths.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ial_pkg;

  // Default list depth
  localparam int unsigned DefaultCapacity = 16;

  // Fixed field widths
  localparam int unsigned ValW    = 32;
  localparam int unsigned IdxW    = 5;
  localparam int unsigned CmdW    = 2;
  localparam int unsigned StatW   = 3;
  localparam int unsigned FoundW  = 4;
  localparam int unsigned CountW  = 5;
  localparam int unsigned TotalW  = 36;
  // Accumulator wide enough for 256 entries of 32 bits
  localparam int unsigned SumW    = 40;

  // Command codes; code 3 is unused and changes nothing
  localparam logic [CmdW-1:0] CMD_INSERT = 2'd0;
  localparam logic [CmdW-1:0] CMD_DELETE = 2'd1;
  localparam logic [CmdW-1:0] CMD_FIND   = 2'd2;

  // Status codes
  localparam logic [StatW-1:0] STAT_OK       = 3'd0;
  localparam logic [StatW-1:0] STAT_FULL     = 3'd1;
  localparam logic [StatW-1:0] STAT_EMPTY    = 3'd2;
  localparam logic [StatW-1:0] STAT_BADIDX   = 3'd3;
  localparam logic [StatW-1:0] STAT_NOTFOUND = 3'd4;

  // Sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SH_RD,
    S_SH_WR,
    S_FIX,
    S_SCAN,
    S_FINISH
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/indexed_array_list_top.sv
// Indexed array list: ordered list of signed 32-bit entries with insert, delete and find.
// Uses ial_pkg for codes, widths and the sequencer state type.
//
// The block holds up to CAPACITY entries in a single-port-write, registered-read
// memory and handles one request at a time. A request moves through a small
// sequencer: a decode state; for each entry moved by an insert or a delete, a read
// state and a write state (memory read, then write one place up or down); for an
// accepted insert or delete, a state that stores the inserted value (insert only)
// and updates the count; then a scan that reads every held entry once; and a
// state that loads the result register. The memory read port is shared by
// shifting and scanning. The scan produces min, max and exact sum and, for a
// find, the first matching position. A finished result waits in the output
// register while the next request is accepted.
`timescale 1ns / 1ps
`default_nettype none

module indexed_array_list_top
  import ial_pkg::*;
#(
  parameter int unsigned CAPACITY = DefaultCapacity
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  // Request stream
  input  wire logic          s_axis_tvalid,
  output logic               s_axis_tready,
  // tdata from bit 0: value[31:0], index[36:32], zero fill[39:37]
  input  wire logic [39:0]   s_axis_tdata,
  // tuser from bit 0: cmd[1:0]
  input  wire logic [1:0]    s_axis_tuser,
  // Result stream
  output logic               m_axis_tvalid,
  input  wire logic          m_axis_tready,
  // tdata from bit 0: status[2:0], found_index[6:3], count[11:7], minimum[43:12],
  // maximum[75:44], total[111:76]
  output logic [111:0]       m_axis_tdata
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam int unsigned AW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW = (CntW > IdxW) ? CntW : IdxW;
  localparam int unsigned XW   = CmpW + 1;

  state_e state_q, state_d;

  // Request registers
  logic [CmdW-1:0]         cmd_q;
  logic signed [ValW-1:0]  val_q;
  logic [IdxW-1:0]         idx_q;

  // List state
  logic [CntW-1:0]         cnt_q;
  logic [CntW-1:0]         p_q;
  logic                    up_q;
  logic                    ins_ok_q;

  // Scan state
  logic [CntW-1:0]         s_q;
  logic [CntW-1:0]         pos_q;
  logic                    rv_q;
  logic signed [ValW-1:0]  mn_q;
  logic signed [ValW-1:0]  mx_q;
  logic signed [SumW-1:0]  sum_q;
  logic                    hit_q;
  logic [CntW-1:0]         fidx_q;
  logic [StatW-1:0]        stat_q;

  // Result register
  logic                    m_valid_q;
  logic [StatW-1:0]        res_status_q;
  logic [FoundW-1:0]       res_found_q;
  logic [CountW-1:0]       res_count_q;
  logic signed [ValW-1:0]  res_min_q;
  logic signed [ValW-1:0]  res_max_q;
  logic [TotalW-1:0]       res_total_q;

  // Memory
  logic signed [ValW-1:0]  mem_q [CAPACITY];
  logic signed [ValW-1:0]  rdata_q;
  logic [AW-1:0]           mem_ra;
  logic [AW-1:0]           mem_wa;
  logic signed [ValW-1:0]  mem_wd;
  logic                    mem_we;

  // Decode helpers
  logic                    req_acc;
  logic                    is_full;
  logic                    ins_bad;
  logic                    del_bad;
  logic                    ins_move;
  logic                    del_move;
  logic [CntW-1:0]         p_nx;
  logic                    more;
  logic                    scan_go;
  logic                    load_res;

  assign req_acc  = s_axis_tvalid && s_axis_tready;
  assign is_full  = (cnt_q == CntW'(CAPACITY));
  assign ins_bad  = CmpW'(idx_q) > CmpW'(cnt_q);
  assign del_bad  = CmpW'(idx_q) >= CmpW'(cnt_q);
  assign ins_move = CmpW'(cnt_q) > CmpW'(idx_q);
  assign del_move = (XW'(idx_q) + XW'(1)) < XW'(cnt_q);
  assign p_nx     = up_q ? (p_q - CntW'(1)) : (p_q + CntW'(1));
  assign more     = up_q ? (CmpW'(p_nx) > CmpW'(idx_q))
                         : ((XW'(p_nx) + XW'(1)) < XW'(cnt_q));
  assign scan_go  = s_q < cnt_q;
  assign load_res = !m_valid_q || m_axis_tready;

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (req_acc) state_d = S_DECODE;
      end
      S_DECODE: begin
        state_d = S_SCAN;
        if (cmd_q == CMD_INSERT && !is_full && !ins_bad) begin
          state_d = ins_move ? S_SH_RD : S_FIX;
        end else if (cmd_q == CMD_DELETE && cnt_q != '0 && !del_bad) begin
          state_d = del_move ? S_SH_RD : S_FIX;
        end
      end
      S_SH_RD: state_d = S_SH_WR;
      S_SH_WR: state_d = more ? S_SH_RD : S_FIX;
      S_FIX:   state_d = S_SCAN;
      S_SCAN: begin
        if (!scan_go && !rv_q) state_d = S_FINISH;
      end
      S_FINISH: begin
        if (load_res) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Memory control and handshake
  always_comb begin
    s_axis_tready = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = AW'(p_q);
    mem_wd        = rdata_q;
    mem_ra        = AW'(s_q);
    case (state_q)
      S_IDLE:  s_axis_tready = 1'b1;
      S_SH_RD: mem_ra = up_q ? AW'(p_q - CntW'(1)) : AW'(p_q + CntW'(1));
      S_SH_WR: mem_we = 1'b1;
      S_FIX: begin
        mem_we = ins_ok_q;
        mem_wa = AW'(idx_q);
        mem_wd = val_q;
      end
      default: ;
    endcase
  end

  // Entry storage with registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) mem_q[mem_wa] <= mem_wd;
    rdata_q <= mem_q[mem_ra];
  end

  // Request capture, shifting and scan datapath
  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      cmd_q <= s_axis_tuser;
      val_q <= s_axis_tdata[31:0];
      idx_q <= s_axis_tdata[36:32];
    end
    case (state_q)
      S_DECODE: begin
        up_q     <= (cmd_q == CMD_INSERT);
        ins_ok_q <= (cmd_q == CMD_INSERT);
        p_q      <= (cmd_q == CMD_INSERT) ? cnt_q : CntW'(idx_q);
        s_q      <= '0;
        mn_q     <= {1'b0, {(ValW-1){1'b1}}};
        mx_q     <= {1'b1, {(ValW-1){1'b0}}};
        sum_q    <= '0;
        hit_q    <= 1'b0;
        fidx_q   <= '0;
        stat_q   <= STAT_OK;
        if (cmd_q == CMD_INSERT) begin
          if (is_full) stat_q <= STAT_FULL;
          else if (ins_bad) stat_q <= STAT_BADIDX;
        end else if (cmd_q == CMD_DELETE) begin
          if (cnt_q == '0) stat_q <= STAT_EMPTY;
          else if (del_bad) stat_q <= STAT_BADIDX;
        end else if (cmd_q == CMD_FIND) begin
          stat_q <= STAT_NOTFOUND;
        end
      end
      S_SH_WR: p_q <= p_nx;
      S_SCAN: begin
        // Issue one read a cycle, fold the data of the previous read
        if (scan_go) s_q <= s_q + CntW'(1);
        pos_q <= s_q;
        if (rv_q) begin
          if (rdata_q < mn_q) mn_q <= rdata_q;
          if (rdata_q > mx_q) mx_q <= rdata_q;
          sum_q <= sum_q + SumW'(rdata_q);
          if (cmd_q == CMD_FIND && !hit_q && rdata_q == val_q) begin
            hit_q  <= 1'b1;
            fidx_q <= pos_q;
            stat_q <= STAT_OK;
          end
        end
      end
      default: ;
    endcase
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (state_q == S_FINISH && load_res) begin
      res_status_q <= stat_q;
      res_found_q  <= FoundW'(fidx_q);
      res_count_q  <= CountW'(cnt_q);
      res_min_q    <= mn_q;
      res_max_q    <= mx_q;
      res_total_q  <= sum_q[TotalW-1:0];
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      rv_q      <= 1'b0;
      m_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rv_q    <= (state_q == S_SCAN) && scan_go;
      if (state_q == S_FIX) begin
        cnt_q <= ins_ok_q ? (cnt_q + CntW'(1)) : (cnt_q - CntW'(1));
      end
      if (state_q == S_FINISH && load_res) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {res_total_q, res_max_q, res_min_q,
                          res_count_q, res_found_q, res_status_q};

`ifndef SYNTHESIS
  // Count never exceeds the list depth
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(CAPACITY))
    else $error("entry count above capacity");

  // Shift writes stay inside the memory
  a_wr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SH_WR) |-> (p_q < CntW'(CAPACITY)))
    else $error("shift write beyond capacity");

  // One request at a time
  a_one_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_acc |=> !s_axis_tready)
    else $error("request accepted while busy");

  // A full result reports a full list
  a_full_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && res_status_q == STAT_FULL) |-> (res_count_q == CountW'(CAPACITY)))
    else $error("full status with wrong count");
`endif

endmodule

`default_nettype wire
